### src/gb5_pkg.sv
// Shared types and constants for the 5x5 Gaussian blur core.
// No dependencies; every other file in src/ except gb5_ram refers to this package by scoped names.
`timescale 1ns / 1ps

package gb5_pkg;

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int COL_W        = 10;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int LANES        = 4;
    localparam int LINE_W       = LANES * PIX_W;
    localparam int WIN          = 5;
    localparam int GS_W         = 11;   // sum of up to eight pixels
    localparam int ACC_W        = 24;   // 65540 * 255 < 2**24
    localparam int N_GROUPS     = 6;
    localparam int TDATA_W      = 32;

    // APB register map
    localparam int               APB_ADDR_W      = 3;
    localparam int               APB_DATA_W      = 32;
    localparam logic [APB_ADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Q0.16 weights, one per symmetry class of the kernel:
    // corner, outer edge, outer middle, inner diagonal, inner axis, center
    localparam logic [ACC_W-1:0] WEIGHTS [N_GROUPS] = '{
        24'd195, 24'd872, 24'd1438, 24'd3908, 24'd6444, 24'd10624
    };
    localparam logic [ACC_W:0] ROUND_HALF = 25'd32768;
    localparam int             FRAC_W     = 16;

    // one column of the window: [0] oldest row .. [4] current row
    typedef logic [WIN-1:0][PIX_W-1:0] t_column;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] px;
        logic             interior;  // completes the window of (row-2, col-2)
        logic             border;    // passes through unchanged
    } t_tag;

    typedef struct packed {
        logic             last;
        logic             filtered;
        logic [PIX_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_result;

endpackage

### src/gb5_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gb5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/gb5_line_buf.sv
// Raster position counters and the four-row line store (read-modify-write).
// Depends on gb5_pkg and gb5_ram.
`timescale 1ns / 1ps

module gb5_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_accept,
    input  logic [gb5_pkg::PIX_W-1:0]        i_pixel,
    input  logic [gb5_pkg::CFG_WIDTH_W-1:0]  i_image_width,
    input  logic [gb5_pkg::CFG_HEIGHT_W-1:0] i_image_height,
    output logic                             o_valid,
    output gb5_pkg::t_column                 o_column,
    output gb5_pkg::t_tag                    o_tag
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WCMP = (CW + 1 > gb5_pkg::CFG_WIDTH_W) ? CW + 1 : gb5_pkg::CFG_WIDTH_W;
    localparam int HCMP = (RW + 1 > gb5_pkg::CFG_HEIGHT_W) ? RW + 1 : gb5_pkg::CFG_HEIGHT_W;
    localparam int EDGE = 2;
    localparam int REACH = 4;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [WCMP-1:0] w_cfg, w_eff, c_ext, c_nxt;
    logic [HCMP-1:0] h_cfg, h_eff, r_inc, r_ext, r_nxt;
    logic            interior, border;

    // S1 registers
    logic                          r_s1_valid;
    gb5_pkg::t_tag                 r_s1_tag;
    logic [1:0]                    r_s1_slot;
    logic [CW-1:0]                 r_s1_addr;
    logic                          r_s1_fwd;
    logic [gb5_pkg::LINE_W-1:0]    r_s1_fwd_data;

    logic [gb5_pkg::LINE_W-1:0]    ram_q, line_old, line_new;
    logic                          wr_en;

    // clamp the size registers
    assign w_cfg = WCMP'(i_image_width);
    assign h_cfg = HCMP'(i_image_height);

    always_comb begin
        if (w_cfg == '0) begin
            w_eff = WCMP'(1);
        end else if (w_cfg > WCMP'(MAX_WIDTH)) begin
            w_eff = WCMP'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (h_cfg == '0) begin
            h_eff = HCMP'(1);
        end else if (h_cfg > HCMP'(MAX_HEIGHT)) begin
            h_eff = HCMP'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end
    end

    // position of this word, and the position after it
    always_comb begin
        c_ext = WCMP'(r_col);
        r_inc = HCMP'(r_row);
        if (c_ext >= w_eff) begin
            c_ext = '0;
            r_inc = HCMP'(r_row) + HCMP'(1);
        end
        r_ext = (r_inc >= h_eff) ? '0 : r_inc;

        c_nxt = c_ext + WCMP'(1);
        r_nxt = r_ext;
        if (c_nxt >= w_eff) begin
            c_nxt = '0;
            r_nxt = r_ext + HCMP'(1);
            if (r_nxt >= h_eff) begin
                r_nxt = '0;
            end
        end

        interior = (r_ext >= HCMP'(REACH)) && (c_ext >= WCMP'(REACH));
        border   = (r_ext < HCMP'(EDGE)) || (r_ext + HCMP'(EDGE) >= h_eff) ||
                   (c_ext < WCMP'(EDGE)) || (c_ext + WCMP'(EDGE) >= w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col <= c_nxt[CW-1:0];
                r_row <= r_nxt[RW-1:0];
            end
            if (i_en) begin
                r_s1_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_tag.row      <= r_ext[gb5_pkg::ROW_W-1:0];
            r_s1_tag.col      <= c_ext[gb5_pkg::COL_W-1:0];
            r_s1_tag.px       <= i_pixel;
            r_s1_tag.interior <= interior;
            r_s1_tag.border   <= border;
            r_s1_slot         <= r_ext[1:0];
            r_s1_addr         <= c_ext[CW-1:0];
            // write-back to the same column in this cycle: RAM read is stale
            r_s1_fwd          <= wr_en && (r_s1_addr == c_ext[CW-1:0]);
            r_s1_fwd_data     <= line_new;
        end
    end

    // lane k of a line word holds the row whose index is k mod 4
    assign line_old = r_s1_fwd ? r_s1_fwd_data : ram_q;
    assign wr_en    = i_en && r_s1_valid;

    always_comb begin
        line_new = line_old;
        line_new[r_s1_slot * gb5_pkg::PIX_W +: gb5_pkg::PIX_W] = r_s1_tag.px;
    end

    always_comb begin
        for (int i = 0; i < gb5_pkg::LANES; i++) begin
            o_column[i] = line_old[gb5_pkg::PIX_W * 32'(2'(r_s1_slot + 2'(i)))
                                   +: gb5_pkg::PIX_W];
        end
        o_column[gb5_pkg::LANES] = r_s1_tag.px;
    end

    gb5_ram #(
        .WIDTH (gb5_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (line_new),
        .i_rd_en   (i_accept),
        .i_rd_addr (c_ext[CW-1:0]),
        .o_rd_data (ram_q)
    );

    assign o_valid = r_s1_valid;
    assign o_tag   = r_s1_tag;

endmodule

### src/gb5_kernel.sv
// 5x5 window and pipelined weighted sum: group sums, products, partials, round.
// Depends on gb5_pkg.
`timescale 1ns / 1ps

module gb5_kernel (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  gb5_pkg::t_column          i_column,
    input  gb5_pkg::t_tag             i_tag,
    output logic                      o_valid,
    output gb5_pkg::t_tag             o_tag,
    output logic [gb5_pkg::PIX_W-1:0] o_value
);

    localparam int W = gb5_pkg::WIN;
    localparam int G = gb5_pkg::GS_W;
    localparam int A = gb5_pkg::ACC_W;
    localparam int F = gb5_pkg::FRAC_W;

    // r_win[i][j]: row i (0 oldest), column j (0 oldest)
    logic [W-1:0][W-1:0][gb5_pkg::PIX_W-1:0] r_win;

    logic r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    gb5_pkg::t_tag r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;

    logic [G-1:0] g_sum [gb5_pkg::N_GROUPS];
    logic [G-1:0] r_g   [gb5_pkg::N_GROUPS];
    logic [A-1:0] r_p   [gb5_pkg::N_GROUPS];
    logic [A-1:0] r_part_a, r_part_b;
    logic [A:0]   total;
    logic [A-F:0] unused_guard;

    // sum pixels that share a weight
    always_comb begin
        g_sum[0] = G'(r_win[0][0]) + G'(r_win[0][4]) + G'(r_win[4][0]) + G'(r_win[4][4]);
        g_sum[1] = G'(r_win[0][1]) + G'(r_win[0][3]) + G'(r_win[1][0]) + G'(r_win[3][0])
                 + G'(r_win[4][1]) + G'(r_win[4][3]) + G'(r_win[1][4]) + G'(r_win[3][4]);
        g_sum[2] = G'(r_win[0][2]) + G'(r_win[2][0]) + G'(r_win[4][2]) + G'(r_win[2][4]);
        g_sum[3] = G'(r_win[1][1]) + G'(r_win[1][3]) + G'(r_win[3][1]) + G'(r_win[3][3]);
        g_sum[4] = G'(r_win[1][2]) + G'(r_win[2][1]) + G'(r_win[3][2]) + G'(r_win[2][3]);
        g_sum[5] = G'(r_win[2][2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            if (i_valid) begin
                for (int i = 0; i < W; i++) begin
                    for (int j = 0; j < W - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][W-1] <= i_column[i];
                end
            end
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_tag <= i_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
            r_s5_tag <= r_s4_tag;
            for (int k = 0; k < gb5_pkg::N_GROUPS; k++) begin
                r_g[k] <= g_sum[k];
                r_p[k] <= A'(r_g[k]) * gb5_pkg::WEIGHTS[k];
            end
            r_part_a <= r_p[0] + r_p[1] + r_p[2];
            r_part_b <= r_p[3] + r_p[4] + r_p[5];
        end
    end

    // round to nearest, clamp at full scale
    assign total        = (A+1)'(r_part_a) + (A+1)'(r_part_b) + gb5_pkg::ROUND_HALF;
    assign unused_guard = total[A:F];
    assign o_value      = (unused_guard[A-F:gb5_pkg::PIX_W] != '0)
                        ? '1 : unused_guard[gb5_pkg::PIX_W-1:0];

    assign o_valid = r_s5_valid;
    assign o_tag   = r_s5_tag;

endmodule

### src/gb5_out_q.sv
// Small result queue: takes up to two words a cycle, hands out one while the reader is ready.
// Depends on gb5_pkg.
`timescale 1ns / 1ps

module gb5_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  gb5_pkg::t_result i_word0,
    input  gb5_pkg::t_result i_word1,
    input  logic             i_ready,
    output logic             o_valid,
    output gb5_pkg::t_result o_word,
    output logic             o_room
);

    gb5_pkg::t_result                r_q [gb5_pkg::Q_DEPTH];
    logic [gb5_pkg::Q_PTR_W-1:0]     r_wp, r_rp;
    logic [gb5_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                            pop;

    assign o_valid = (r_cnt != '0);
    assign o_word  = r_q[r_rp];
    assign pop     = o_valid && i_ready;
    // room for a two-word push regardless of this cycle's pop
    assign o_room  = (r_cnt <= gb5_pkg::Q_CNT_W'(gb5_pkg::Q_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + gb5_pkg::Q_PTR_W'(i_push_n);
            r_rp  <= r_rp + gb5_pkg::Q_PTR_W'(pop);
            r_cnt <= r_cnt + gb5_pkg::Q_CNT_W'(i_push_n) - gb5_pkg::Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_q[r_wp] <= i_word0;
        end
        if (i_push_n == 2'd2) begin
            r_q[gb5_pkg::Q_PTR_W'(r_wp + gb5_pkg::Q_PTR_W'(1))] <= i_word1;
        end
    end

endmodule

### src/gaussian_blur_5x5_core.sv
// Top level of the 5x5 Gaussian blur core: APB registers, stream ports, pipeline glue.
// Depends on gb5_pkg, gb5_line_buf, gb5_kernel and gb5_out_q.
//
// Usage
//   Pixels of one 8-bit channel enter in raster order on the s_axis word channel.
//   Results leave on m_axis: row, column and value in tdata, a filtered flag in
//   tuser, and tlast on the last result caused by an input word. Interior pixels
//   (two or more from every edge) come out Gaussian filtered when input (r+2,c+2)
//   arrives; border pixels pass through on arrival. An input causing both emits the
//   interior result first. Image size comes from two APB registers (width at 0x0,
//   height at 0x4), which the user writes only while the core is idle (unchecked).
// Timing
//   One input word per cycle while s_axis_tready is high. The first result word
//   of an input is valid on m_axis after these registered steps: line store read
//   at the accept edge, then window load, group sums, products, partial sums and
//   the output queue write. Output bandwidth is one word a cycle while m_axis_tready
//   is high; words causing two results can briefly pull s_axis_tready low.
// Reset and stall
//   Reset clears the position to (0,0), the window and the pipeline; the line
//   store is not cleared and needs no clearing pass. When m_axis stalls, the
//   output queue fills; once it holds three words s_axis_tready drops and the
//   whole pipeline freezes in place.
`timescale 1ns / 1ps

module gaussian_blur_5x5_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gb5_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gb5_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gb5_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // pixel input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gb5_pkg::PIX_W-1:0]          s_axis_tdata,   // [7:0] pixel
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gb5_pkg::TDATA_W-1:0]        m_axis_tdata,   // [11:0] out_row,
                                                               // [21:12] out_col,
                                                               // [29:22] value, [31:30] 0
    output logic                               m_axis_tuser,   // [0] filtered
    output logic                               m_axis_tlast
);

    logic [gb5_pkg::CFG_WIDTH_W-1:0]  r_image_width;
    logic [gb5_pkg::CFG_HEIGHT_W-1:0] r_image_height;

    logic             en, accept, cfg_wr;
    logic             lb_valid, k_valid;
    gb5_pkg::t_column lb_column;
    gb5_pkg::t_tag    lb_tag, k_tag;
    logic [gb5_pkg::PIX_W-1:0] k_value;

    logic [1:0]       push_n;
    gb5_pkg::t_result int_word, brd_word, word0, word1, q_word;
    logic             q_room;

    // ---------------- APB registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= gb5_pkg::WIDTH_RESET;
            r_image_height <= gb5_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                gb5_pkg::REG_WIDTH_ADDR:  r_image_width  <= pwdata[gb5_pkg::CFG_WIDTH_W-1:0];
                gb5_pkg::REG_HEIGHT_ADDR: r_image_height <= pwdata[gb5_pkg::CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            gb5_pkg::REG_WIDTH_ADDR:  prdata = gb5_pkg::APB_DATA_W'(r_image_width);
            gb5_pkg::REG_HEIGHT_ADDR: prdata = gb5_pkg::APB_DATA_W'(r_image_height);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // All stages advance together; they hold while the queue lacks room for two.
    assign en            = q_room;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    gb5_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_line_buf (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_accept       (accept),
        .i_pixel        (s_axis_tdata),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_valid        (lb_valid),
        .o_column       (lb_column),
        .o_tag          (lb_tag)
    );

    gb5_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (lb_valid),
        .i_column (lb_column),
        .i_tag    (lb_tag),
        .o_valid  (k_valid),
        .o_tag    (k_tag),
        .o_value  (k_value)
    );

    // ---------------- result words ----------------
    // filtered pixel sits two rows and two columns behind the input position
    always_comb begin
        int_word.row      = k_tag.row - gb5_pkg::ROW_W'(2);
        int_word.col      = k_tag.col - gb5_pkg::COL_W'(2);
        int_word.value    = k_value;
        int_word.filtered = 1'b1;
        int_word.last     = !k_tag.border;

        brd_word.row      = k_tag.row;
        brd_word.col      = k_tag.col;
        brd_word.value    = k_tag.px;
        brd_word.filtered = 1'b0;
        brd_word.last     = 1'b1;

        push_n = 2'd0;
        word0  = brd_word;
        word1  = brd_word;
        if (en && k_valid) begin
            if (k_tag.interior) begin
                word0  = int_word;
                push_n = k_tag.border ? 2'd2 : 2'd1;
            end else if (k_tag.border) begin
                push_n = 2'd1;
            end
        end
    end

    gb5_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_word0  (word0),
        .i_word1  (word1),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_word   (q_word),
        .o_room   (q_room)
    );

    assign m_axis_tdata = {2'b00, q_word.value, q_word.col, q_word.row};
    assign m_axis_tuser = q_word.filtered;
    assign m_axis_tlast = q_word.last;

endmodule
